// ----- src/caesar_vigenere_decrypt_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the Caesar/Vigenere decryptor
// Each macro samples on clk and is disabled during rst.
// ----------------------------------------------------------------------------
`ifndef CAESAR_VIGENERE_DECRYPT_TOP_MACROS_SVH
`define CAESAR_VIGENERE_DECRYPT_TOP_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define CVD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define CVD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/cvd_pkg.sv -----
// ----------------------------------------------------------------------------
// cvd_pkg
// Shared widths, register indexes, types and helper functions of the
// Caesar/Vigenere decryptor.
// ----------------------------------------------------------------------------
`default_nettype none

package cvd_pkg;

  localparam int KEY_MAX_DEFAULT = 12;

  localparam int CHAR_W       = 8;
  localparam int CAESAR_KEY_W = 16;
  localparam int KEY_LEN_W    = 4;
  localparam int LETTER_W     = 5;
  localparam int DIGIT_W      = 4;
  localparam int CFG_DATA_W   = 60;
  localparam int CFG_IDX_W    = 2;

  localparam int DIGIT_SPAN  = 10;
  localparam int LETTER_SPAN = 26;

  localparam logic [CHAR_W-1:0] CHAR_0       = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_9       = 8'd57;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'd65;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'd90;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'd97;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'd122;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAESAR_KEY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LETTERS = 2'd3;

  typedef enum logic {
    MODE_CAESAR   = 1'b0,
    MODE_VIGENERE = 1'b1
  } cvd_mode_e;

  typedef struct packed {
    logic [DIGIT_W-1:0]  dshift;
    logic [LETTER_W-1:0] lshift;
  } cvd_shift_t;

  typedef struct packed {
    cvd_mode_e            mode;
    cvd_shift_t           caesar;
    logic [KEY_LEN_W-1:0] key_len;
  } cvd_cfg_t;

  // x mod 10 through a reciprocal multiply and one correction step
  function automatic logic [DIGIT_W-1:0] mod10_u16(input logic [CAESAR_KEY_W-1:0] x);
    logic [31:0] prod;
    logic [12:0] q;
    logic [16:0] r;
    prod = 32'(x) * 32'd52428;
    q    = prod[31:19];
    r    = 17'(x) - 17'(q) * 17'(DIGIT_SPAN);
    if (r >= 17'(DIGIT_SPAN)) begin
      r = r - 17'(DIGIT_SPAN);
    end
    return r[DIGIT_W-1:0];
  endfunction

  // x mod 26 through a reciprocal multiply and one correction step
  function automatic logic [LETTER_W-1:0] mod26_u16(input logic [CAESAR_KEY_W-1:0] x);
    logic [32:0] prod;
    logic [11:0] q;
    logic [16:0] r;
    prod = 33'(x) * 33'd80659;
    q    = prod[32:21];
    r    = 17'(x) - 17'(q) * 17'(LETTER_SPAN);
    if (r >= 17'(LETTER_SPAN)) begin
      r = r - 17'(LETTER_SPAN);
    end
    return r[LETTER_W-1:0];
  endfunction

  // Wrap a key letter index into 0..25 and derive its digit shift
  function automatic cvd_shift_t letter_shift(input logic [LETTER_W-1:0] k5);
    logic [LETTER_W-1:0] k;
    logic [LETTER_W-1:0] d;
    cvd_shift_t          s;
    k = (k5 >= 5'(LETTER_SPAN)) ? k5 - 5'(LETTER_SPAN) : k5;
    if (k >= 5'(2 * DIGIT_SPAN)) begin
      d = k - 5'(2 * DIGIT_SPAN);
    end else if (k >= 5'(DIGIT_SPAN)) begin
      d = k - 5'(DIGIT_SPAN);
    end else begin
      d = k;
    end
    s.lshift = k;
    s.dshift = d[DIGIT_W-1:0];
    return s;
  endfunction

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return c inside {[CHAR_0:CHAR_9]};
  endfunction

  function automatic logic is_upper(input logic [CHAR_W-1:0] c);
    return c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]};
  endfunction

  function automatic logic is_lower(input logic [CHAR_W-1:0] c);
    return c inside {[CHAR_LOWER_A:CHAR_LOWER_Z]};
  endfunction

  function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
    return is_digit(c) || is_upper(c) || is_lower(c);
  endfunction

endpackage

`default_nettype wire

// ----- src/cvd_stream_if.sv -----
// ----------------------------------------------------------------------------
// cvd_in_if / cvd_out_if
// Valid/ready character channels into and out of the decryptor.
// ----------------------------------------------------------------------------
`default_nettype none

interface cvd_in_if;
  import cvd_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] in_char;
  logic              in_last;

  modport source (output valid, output in_char, output in_last, input ready);
  modport sink   (input valid, input in_char, input in_last, output ready);
endinterface

interface cvd_out_if;
  import cvd_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              out_last;

  modport source (output valid, output out_char, output out_last, input ready);
  modport sink   (input valid, input out_char, input out_last, output ready);
endinterface

`default_nettype wire

// ----- src/cvd_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// cvd_cfg_regs
// Configuration registers. Shift amounts are reduced on write so the
// datapath only selects them.
// ----------------------------------------------------------------------------
`default_nettype none

module cvd_cfg_regs #(
  parameter int KEY_MAX = cvd_pkg::KEY_MAX_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [cvd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cvd_pkg::CFG_DATA_W-1:0]   cfg_data,
  output cvd_pkg::cvd_cfg_t                cfg,
  output cvd_pkg::cvd_shift_t              key_shift [KEY_MAX]
);
  import cvd_pkg::*;

  logic [KEY_LEN_W-1:0] len_wr;

  // clamp the written length into 1..KEY_MAX
  always_comb begin
    len_wr = cfg_data[KEY_LEN_W-1:0];
    if (len_wr == '0) begin
      len_wr = KEY_LEN_W'(1);
    end else if (len_wr > KEY_LEN_W'(KEY_MAX)) begin
      len_wr = KEY_LEN_W'(KEY_MAX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode    <= MODE_CAESAR;
      cfg.caesar  <= '0;
      cfg.key_len <= KEY_LEN_W'(1);
      for (int j = 0; j < KEY_MAX; j++) begin
        key_shift[j] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE: begin
          cfg.mode <= cvd_mode_e'(cfg_data[0]);
        end
        CFG_CAESAR_KEY: begin
          cfg.caesar.dshift <= mod10_u16(cfg_data[CAESAR_KEY_W-1:0]);
          cfg.caesar.lshift <= mod26_u16(cfg_data[CAESAR_KEY_W-1:0]);
        end
        CFG_KEY_LENGTH: begin
          cfg.key_len <= len_wr;
        end
        CFG_KEY_LETTERS: begin
          for (int j = 0; j < KEY_MAX; j++) begin
            key_shift[j] <= letter_shift(cfg_data[LETTER_W*j +: LETTER_W]);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/cvd_key_sched.sv -----
// ----------------------------------------------------------------------------
// cvd_key_sched
// Key position counter and selection of the shift pair for the next
// accepted character.
// ----------------------------------------------------------------------------
`default_nettype none

module cvd_key_sched #(
  parameter int KEY_MAX = cvd_pkg::KEY_MAX_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic                last,
  input  cvd_pkg::cvd_cfg_t   cfg,
  input  cvd_pkg::cvd_shift_t key_shift [KEY_MAX],
  output cvd_pkg::cvd_shift_t shift
);
  import cvd_pkg::*;

  localparam int POS_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

  logic [POS_W-1:0]     pos;
  logic [POS_W-1:0]     pos_next;
  logic [POS_W-1:0]     pos_use;
  logic [KEY_LEN_W-1:0] pos_inc;

  always_comb begin
    // fall back to slot zero if the length was lowered to or below the position
    pos_use = (KEY_LEN_W'(pos) >= cfg.key_len) ? '0 : pos;
    shift   = (cfg.mode == MODE_VIGENERE) ? key_shift[pos_use] : cfg.caesar;
    pos_inc = KEY_LEN_W'(pos_use) + KEY_LEN_W'(1);
    if (last || pos_inc >= cfg.key_len) begin
      pos_next = '0;
    end else begin
      pos_next = pos_inc[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (advance) begin
      pos <= pos_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/cvd_char_decode.sv -----
// ----------------------------------------------------------------------------
// cvd_char_decode
// Shift one character back within its class (digit, upper, lower); all
// other codes pass unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module cvd_char_decode (
  input  logic [cvd_pkg::CHAR_W-1:0] cipher,
  input  cvd_pkg::cvd_shift_t        shift,
  output logic [cvd_pkg::CHAR_W-1:0] plain
);
  import cvd_pkg::*;

  function automatic logic [CHAR_W-1:0] shift_back(
    input logic [CHAR_W-1:0]   c,
    input logic [CHAR_W-1:0]   base,
    input logic [LETTER_W-1:0] span,
    input logic [LETTER_W-1:0] amt
  );
    logic [LETTER_W-1:0] off;
    logic [LETTER_W:0]   adj;
    off = LETTER_W'(c - base);
    if (off < amt) begin
      adj = (LETTER_W+1)'(off) + (LETTER_W+1)'(span) - (LETTER_W+1)'(amt);
    end else begin
      adj = (LETTER_W+1)'(off) - (LETTER_W+1)'(amt);
    end
    return base + CHAR_W'(adj);
  endfunction

  always_comb begin
    if (is_digit(cipher)) begin
      plain = shift_back(cipher, CHAR_0, LETTER_W'(DIGIT_SPAN), LETTER_W'(shift.dshift));
    end else if (is_upper(cipher)) begin
      plain = shift_back(cipher, CHAR_UPPER_A, LETTER_W'(LETTER_SPAN), shift.lshift);
    end else if (is_lower(cipher)) begin
      plain = shift_back(cipher, CHAR_LOWER_A, LETTER_W'(LETTER_SPAN), shift.lshift);
    end else begin
      plain = cipher;
    end
  end

endmodule

`default_nettype wire

// ----- src/caesar_vigenere_decrypt_top.sv -----
// ----------------------------------------------------------------------------
// caesar_vigenere_decrypt_top
// Streaming Caesar/Vigenere decryptor. It takes one ciphertext character per
// cycle and returns one plaintext character per cycle while the output side
// is ready; a stalled output holds the flow back. The rate is set by
// the two-register pipeline: an input register that captures the character
// with its shift pair, and a result register behind the class-wise shift
// logic. Either register holds while the other keeps moving, so a stalled
// result stops new characters only once the input register is full too. In
// Caesar mode letters shift back by key mod 26 and digits by key mod 10; in
// Vigenere mode the key letter at the current key position gives the shift.
// The key position steps on every character and returns to the first key
// letter after a character marked last or at the end of the key. Write the
// configuration only while no character is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "caesar_vigenere_decrypt_top_macros.svh"

module caesar_vigenere_decrypt_top #(
  parameter int KEY_MAX = cvd_pkg::KEY_MAX_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  cvd_in_if.sink                         in,
  cvd_out_if.source                      out,
  input  logic                           cfg_we,
  input  logic [cvd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cvd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cvd_pkg::*;

  // configuration and key schedule
  cvd_cfg_t   cfg;
  cvd_shift_t key_shift [KEY_MAX];
  cvd_shift_t sel_shift;

  // pipeline control
  logic in_ready;
  logic in_take;
  logic s2_free;
  logic s1_move;

  // input register
  logic              s1_valid;
  logic [CHAR_W-1:0] s1_char;
  logic              s1_last;
  cvd_shift_t        s1_shift;

  // result register
  logic              s2_valid;
  logic [CHAR_W-1:0] s2_char;
  logic              s2_last;

  logic [CHAR_W-1:0] plain;

  cvd_cfg_regs #(
    .KEY_MAX (KEY_MAX)
  ) u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .key_shift (key_shift)
  );

  // Advance the key position on every accepted character; the selected
  // shift pair travels with the character into the input register.
  cvd_key_sched #(
    .KEY_MAX (KEY_MAX)
  ) u_key_sched (
    .clk       (clk),
    .rst       (rst),
    .advance   (in_take),
    .last      (in.in_last),
    .cfg       (cfg),
    .key_shift (key_shift),
    .shift     (sel_shift)
  );

  cvd_char_decode u_char_decode (
    .cipher (s1_char),
    .shift  (s1_shift),
    .plain  (plain)
  );

  // The result register frees up when empty or when its transaction
  // completes; the input register moves whenever the result register can
  // take its content, so a new character is taken in the same cycle.
  assign s2_free  = !s2_valid || out.ready;
  assign s1_move  = s1_valid && s2_free;
  assign in_ready = !s1_valid || s2_free;
  assign in_take  = in.valid && in_ready;

  assign in.ready     = in_ready;
  assign out.valid    = s2_valid;
  assign out.out_char = s2_char;
  assign out.out_last = s2_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in.valid;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
    end
  end

  // Payload: load on the move, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_char  <= in.in_char;
      s1_last  <= in.in_last;
      s1_shift <= sel_shift;
    end
    if (s1_move) begin
      s2_char <= plain;
      s2_last <= s1_last;
    end
  end

  // Back-pressure only when both registers are full and the output stalls.
  `CVD_ASSERT_SAME(a_ready_low_only_when_full, !in_ready,
    s1_valid && s2_valid && !out.ready, "input stalled with room in the pipeline")
  // Characters outside the three classes leave unchanged.
  `CVD_ASSERT_NEXT(a_other_passes, s1_move && !is_alnum(s1_char),
    s2_char == $past(s1_char), "non-alphanumeric character altered")
  // Digits stay digits and capitals stay capitals.
  `CVD_ASSERT_NEXT(a_digit_class, s1_move && is_digit(s1_char),
    is_digit(s2_char), "digit left its class")
  `CVD_ASSERT_NEXT(a_upper_class, s1_move && is_upper(s1_char),
    is_upper(s2_char), "capital letter left its class")

endmodule

`default_nettype wire
